### src/gcr_pkg.sv
package gcr_pkg;

  localparam int PIXEL_LANES     = 8;
  localparam int CURSOR_ROWS     = 16;
  localparam int RESULT_ROWS_MAX = 16;

  localparam logic [7:0] NUL_CODE   = 8'd0;
  localparam logic [7:0] BLANK_CODE = 8'd32;

  typedef enum logic [1:0] {
    OP_LOAD_FONT   = 2'd0,
    OP_LOAD_CURSOR = 2'd1,
    OP_DRAW        = 2'd2,
    OP_DRAW_CURSOR = 2'd3
  } op_e;

  localparam logic [2:0] REG_FONT_WIDTH   = 3'd0;
  localparam logic [2:0] REG_FONT_HEIGHT  = 3'd1;
  localparam logic [2:0] REG_LINE_PITCH   = 3'd2;
  localparam logic [2:0] REG_FRAME_BASE   = 3'd3;
  localparam logic [2:0] REG_CARET_COLOR  = 3'd4;

  localparam logic [3:0]  RST_FONT_WIDTH   = 4'd8;
  localparam logic [4:0]  RST_FONT_HEIGHT  = 5'd16;
  localparam logic [12:0] RST_LINE_PITCH   = 13'd1024;
  localparam logic [31:0] RST_FRAME_BASE   = 32'h0000_0000;
  localparam logic [31:0] RST_CARET_COLOR  = 32'h00FF_FFFF;

  typedef struct packed {
    logic [3:0]  font_width;
    logic [4:0]  font_height;
    logic [12:0] line_pitch;
    logic [31:0] frame_base;
    logic [31:0] caret_color;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  char_code;
    logic [3:0]  glyph_row;
    logic [7:0]  glyph_bits;
    logic [8:0]  column;
    logic [7:0]  cell_row;
    logic [31:0] fg_color;
    logic [31:0] bg_color;
  } in_item_t;

  typedef struct packed {
    logic [31:0]                        pixel_address;
    logic [PIXEL_LANES-1:0][31:0]       pixels;
    logic [PIXEL_LANES-1:0]             pixel_mask;
    logic                               last_row;
  } out_item_t;

  typedef struct packed {
    logic       accept;
    logic       calc_base;
    logic       issue;
    logic [3:0] row;
    logic       last;
  } ctrl_cmd_t;

  typedef struct packed {
    logic       can_issue;
    logic       busy;
    logic [4:0] height;
  } dp_status_t;

endpackage

### src/gcr_in_if.sv
interface gcr_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [7:0]  char_code;
  logic [3:0]  glyph_row;
  logic [7:0]  glyph_bits;
  logic [8:0]  column;
  logic [7:0]  cell_row;
  logic [31:0] fg_color;
  logic [31:0] bg_color;

  modport source (
    output valid, op, char_code, glyph_row, glyph_bits, column, cell_row, fg_color, bg_color,
    input  ready
  );
  modport sink (
    input  valid, op, char_code, glyph_row, glyph_bits, column, cell_row, fg_color, bg_color,
    output ready
  );
endinterface

### src/gcr_out_if.sv
interface gcr_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] pixel_address;
  logic [31:0] pixel_0;
  logic [31:0] pixel_1;
  logic [31:0] pixel_2;
  logic [31:0] pixel_3;
  logic [31:0] pixel_4;
  logic [31:0] pixel_5;
  logic [31:0] pixel_6;
  logic [31:0] pixel_7;
  logic [7:0]  pixel_mask;
  logic        last_row;

  modport source (
    output valid, pixel_address, pixel_0, pixel_1, pixel_2, pixel_3, pixel_4, pixel_5,
           pixel_6, pixel_7, pixel_mask, last_row,
    input  ready
  );
  modport sink (
    input  valid, pixel_address, pixel_0, pixel_1, pixel_2, pixel_3, pixel_4, pixel_5,
           pixel_6, pixel_7, pixel_mask, last_row,
    output ready
  );
endinterface

### src/gcr_ctrl.sv
module gcr_ctrl import gcr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_draw_i,
  output logic       in_ready_o,
  input  dp_status_t st_i,
  output ctrl_cmd_t  cmd_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_BASE = 2'd1;
  localparam logic [1:0] S_ROW  = 2'd2;

  logic [1:0] state_q, state_d;
  logic [3:0] row_q, row_d;
  logic       accept;
  logic       last;

  assign in_ready_o = (state_q == S_IDLE) && !st_i.busy;
  assign accept     = in_valid_i && in_ready_o;
  assign last       = ({1'b0, row_q} + 5'd1) == st_i.height;

  always_comb begin
    state_d       = state_q;
    row_d         = row_q;
    cmd_o         = '0;
    cmd_o.accept  = accept;
    cmd_o.row     = row_q;
    cmd_o.last    = last;
    case (state_q)
      S_IDLE: begin
        if (accept && in_draw_i && (st_i.height != 5'd0)) begin
          state_d = S_BASE;
        end
      end
      S_BASE: begin
        cmd_o.calc_base = 1'b1;
        row_d           = 4'd0;
        state_d         = S_ROW;
      end
      S_ROW: begin
        if (st_i.can_issue) begin
          cmd_o.issue = 1'b1;
          if (last) begin
            state_d = S_IDLE;
          end else begin
            row_d = row_q + 4'd1;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      row_q   <= 4'd0;
    end else begin
      state_q <= state_d;
      row_q   <= row_d;
    end
  end

endmodule

### src/gcr_dp.sv
module gcr_dp import gcr_pkg::*; #(
  parameter int CHAR_COUNT     = 256,
  parameter int MAX_GLYPH_ROWS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  ctrl_cmd_t  cmd_i,
  input  in_item_t   item_i,
  input  cfg_t       cfg_i,
  input  logic       out_ready_i,
  output dp_status_t st_o,
  output logic       out_valid_o,
  output out_item_t  out_item_o
);

  localparam int FontDepth = CHAR_COUNT * MAX_GLYPH_ROWS;
  localparam int FontAw    = $clog2(FontDepth);
  localparam int HeightCap = (MAX_GLYPH_ROWS < RESULT_ROWS_MAX) ? MAX_GLYPH_ROWS
                                                                : RESULT_ROWS_MAX;

  logic [7:0] font_mem [FontDepth];
  logic [7:0] cur_q [CURSOR_ROWS];

  logic [3:0]  eff_w;
  logic [4:0]  eff_h;
  logic        blank;
  logic        code_ok;
  logic        load_font;
  logic        load_cursor;
  logic [FontAw-1:0] waddr;
  logic [FontAw-1:0] raddr;
  logic [25:0] offset;

  logic [7:0]  code_q;
  logic        code_ok_q;
  logic        cursor_mode_q;
  logic [31:0] fg_q;
  logic [31:0] bg_q;
  logic [11:0] lin_q;
  logic [11:0] colw_q;
  logic [31:0] addr_q;

  logic        rdv_q;
  logic [7:0]  rd_font_q;
  logic [7:0]  rd_cur_q;
  logic [31:0] rd_addr_q;
  logic        rd_last_q;

  logic        ov_q;
  out_item_t   out_q;
  out_item_t   out_d;
  logic        out_load;
  logic [7:0]  glyph;

  assign eff_w = (cfg_i.font_width > 4'(PIXEL_LANES)) ? 4'(PIXEL_LANES) : cfg_i.font_width;
  assign eff_h = (cfg_i.font_height > 5'(HeightCap)) ? 5'(HeightCap) : cfg_i.font_height;

  assign blank = (item_i.op == OP_DRAW_CURSOR)
              && (item_i.char_code inside {NUL_CODE, BLANK_CODE});
  assign code_ok     = {1'b0, item_i.char_code} < 9'(CHAR_COUNT);
  assign load_font   = cmd_i.accept && (item_i.op == OP_LOAD_FONT) && code_ok
                    && ({2'b00, item_i.glyph_row} < 6'(MAX_GLYPH_ROWS));
  assign load_cursor = cmd_i.accept && (item_i.op == OP_LOAD_CURSOR);
  assign waddr  = FontAw'(item_i.char_code) * FontAw'(MAX_GLYPH_ROWS)
                + FontAw'(item_i.glyph_row);
  assign raddr  = FontAw'(code_q) * FontAw'(MAX_GLYPH_ROWS) + FontAw'(cmd_i.row);
  assign offset = 26'(lin_q) * 26'(cfg_i.line_pitch) + 26'(colw_q);

  assign out_load     = rdv_q && (!ov_q || out_ready_i);
  assign st_o.can_issue = !rdv_q || out_load;
  assign st_o.busy      = rdv_q;
  assign st_o.height    = eff_h;

  always_ff @(posedge clk_i) begin
    if (load_font) begin
      font_mem[waddr] <= item_i.glyph_bits;
    end
    if (cmd_i.issue) begin
      rd_font_q <= font_mem[raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_cursor) begin
      cur_q[item_i.glyph_row] <= item_i.glyph_bits;
    end
    if (cmd_i.accept) begin
      code_q        <= blank ? BLANK_CODE : item_i.char_code;
      code_ok_q     <= blank ? 1'b1 : code_ok;
      cursor_mode_q <= item_i.op == OP_DRAW_CURSOR;
      fg_q          <= blank ? cfg_i.caret_color : item_i.fg_color;
      bg_q          <= item_i.bg_color;
      lin_q         <= 12'(item_i.cell_row) * 12'(eff_h);
      colw_q        <= 12'(item_i.column) * 12'(eff_w);
    end
    if (cmd_i.calc_base) begin
      addr_q <= cfg_i.frame_base + {4'b0000, offset, 2'b00};
    end else if (cmd_i.issue) begin
      addr_q <= addr_q + {17'd0, cfg_i.line_pitch, 2'b00};
    end
    if (cmd_i.issue) begin
      rd_cur_q  <= cursor_mode_q ? cur_q[cmd_i.row] : 8'h00;
      rd_addr_q <= addr_q;
      rd_last_q <= cmd_i.last;
    end
    if (out_load) begin
      out_q <= out_d;
    end
  end

  always_comb begin
    glyph               = code_ok_q ? rd_font_q : 8'h00;
    out_d.pixel_address = rd_addr_q;
    out_d.last_row      = rd_last_q;
    for (int k = 0; k < PIXEL_LANES; k++) begin
      out_d.pixel_mask[k] = 4'(k) < eff_w;
      if (4'(k) >= eff_w) begin
        out_d.pixels[k] = 32'd0;
      end else if (rd_cur_q[PIXEL_LANES-1-k]) begin
        out_d.pixels[k] = cfg_i.caret_color;
      end else if (glyph[PIXEL_LANES-1-k]) begin
        out_d.pixels[k] = fg_q;
      end else begin
        out_d.pixels[k] = bg_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rdv_q <= 1'b0;
      ov_q  <= 1'b0;
    end else begin
      if (cmd_i.issue) begin
        rdv_q <= 1'b1;
      end else if (out_load) begin
        rdv_q <= 1'b0;
      end
      if (out_load) begin
        ov_q <= 1'b1;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = ov_q;
  assign out_item_o  = out_q;

endmodule

### src/glyph_cell_renderer_core.sv
// Text-cell glyph renderer. Requests arrive on in_i; load requests write one
// font row or one cursor-shape row and produce nothing, draw requests produce
// one result on out_o per glyph row, in row order, with last_row marking the
// final row of the cell. Registers are to be written over the APB port
// only while the block is idle; the block does not enforce this. pready
// is always high and reads return the register value. A draw request
// passes a base-address state, then reads one row per cycle while the
// output has room, a rate set by the single read port of the font memory;
// the next request is taken once its last row leaves the read register.
// A draw with a height of zero is accepted and produces nothing.
// Reset restores the register defaults and empties the pipeline; the font
// and cursor stores are not cleared and must be loaded before use.
// When the receiver stalls, the current row holds in the output register,
// one more row waits behind it, and row reads stop until space opens up.
module glyph_cell_renderer_core import gcr_pkg::*; #(
  parameter int CHAR_COUNT     = 256,
  parameter int MAX_GLYPH_ROWS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  gcr_in_if.sink      in_i,
  gcr_out_if.source   out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t       cfg_q;
  in_item_t   item;
  out_item_t  out_item;
  ctrl_cmd_t  cmd;
  dp_status_t st;
  logic       out_valid;
  logic       cfg_wr;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.font_width   <= RST_FONT_WIDTH;
      cfg_q.font_height  <= RST_FONT_HEIGHT;
      cfg_q.line_pitch   <= RST_LINE_PITCH;
      cfg_q.frame_base   <= RST_FRAME_BASE;
      cfg_q.caret_color  <= RST_CARET_COLOR;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_FONT_WIDTH:   cfg_q.font_width   <= pwdata[3:0];
        REG_FONT_HEIGHT:  cfg_q.font_height  <= pwdata[4:0];
        REG_LINE_PITCH:   cfg_q.line_pitch   <= pwdata[12:0];
        REG_FRAME_BASE:   cfg_q.frame_base   <= pwdata;
        REG_CARET_COLOR:  cfg_q.caret_color  <= pwdata;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_FONT_WIDTH:   prdata = {28'd0, cfg_q.font_width};
      REG_FONT_HEIGHT:  prdata = {27'd0, cfg_q.font_height};
      REG_LINE_PITCH:   prdata = {19'd0, cfg_q.line_pitch};
      REG_FRAME_BASE:   prdata = cfg_q.frame_base;
      REG_CARET_COLOR:  prdata = cfg_q.caret_color;
      default:          prdata = 32'd0;
    endcase
  end

  assign item.op         = in_i.op;
  assign item.char_code  = in_i.char_code;
  assign item.glyph_row  = in_i.glyph_row;
  assign item.glyph_bits = in_i.glyph_bits;
  assign item.column     = in_i.column;
  assign item.cell_row   = in_i.cell_row;
  assign item.fg_color   = in_i.fg_color;
  assign item.bg_color   = in_i.bg_color;

  gcr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_draw_i  (in_i.op inside {OP_DRAW, OP_DRAW_CURSOR}),
    .in_ready_o (in_i.ready),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  gcr_dp #(
    .CHAR_COUNT     (CHAR_COUNT),
    .MAX_GLYPH_ROWS (MAX_GLYPH_ROWS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .item_i      (item),
    .cfg_i       (cfg_q),
    .out_ready_i (out_o.ready),
    .st_o        (st),
    .out_valid_o (out_valid),
    .out_item_o  (out_item)
  );

  assign out_o.valid         = out_valid;
  assign out_o.pixel_address = out_item.pixel_address;
  assign out_o.pixel_0       = out_item.pixels[0];
  assign out_o.pixel_1       = out_item.pixels[1];
  assign out_o.pixel_2       = out_item.pixels[2];
  assign out_o.pixel_3       = out_item.pixels[3];
  assign out_o.pixel_4       = out_item.pixels[4];
  assign out_o.pixel_5       = out_item.pixels[5];
  assign out_o.pixel_6       = out_item.pixels[6];
  assign out_o.pixel_7       = out_item.pixels[7];
  assign out_o.pixel_mask    = out_item.pixel_mask;
  assign out_o.last_row      = out_item.last_row;

  a_no_accept_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st.busy |-> !in_i.ready)
    else $error("request accepted while a glyph row is in flight");

  a_issue_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.issue |-> st.can_issue)
    else $error("row read issued without room in the row pipeline");

  a_mask_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> ((out_o.pixel_mask & (out_o.pixel_mask + 8'd1)) == 8'd0))
    else $error("pixel mask is not a contiguous run of low lanes");

  a_no_idle_issue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.issue && cmd.last) |=> !cmd.issue)
    else $error("row read issued after the last row of a cell");

endmodule

### bench/glyph_cell_renderer_core_test.sv
module glyph_cell_renderer_core_test import gcr_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int GLYPH_ROWS   = 16;
  localparam int DRAIN_CYCLES = 24;
  localparam int LIMIT_CYCLES = 400000;
  localparam int PHASE_ITEMS  = 38;

  typedef enum {STEP_REG_WRITE, STEP_REQUEST} step_kind_e;
  typedef enum {RX_OPEN, RX_COIN, RX_SPARSE, RX_BEAT} stall_e;

  typedef struct {
    step_kind_e  kind;
    logic [2:0]  reg_idx;
    logic [31:0] reg_val;
    in_item_t    req;
    bit          typed;
    out_item_t   res;
  } step_t;

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  gcr_in_if  in_if ();
  gcr_out_if out_if ();

  glyph_cell_renderer_core dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_if),
    .out_o   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  cfg_t        model_cfg;
  logic [7:0]  font_rows [256*GLYPH_ROWS];
  logic [7:0]  cursor_rows [CURSOR_ROWS];
  out_item_t   expected_rows [$];
  logic [7:0]  drawable [$];
  bit          listed [256];
  step_t       steps [$];
  int          mismatches = 0;
  int          sent = 0;
  int          burst_left = 0;
  stall_e      stall_mode = RX_OPEN;
  int          stall_left = 0;
  out_item_t   want_row;
  logic [31:0] got_px [PIXEL_LANES];

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk_i);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic void predict_request(in_item_t it);
    logic [7:0]  code;
    logic [31:0] fg;
    logic [31:0] line_no;
    logic [7:0]  gbits;
    logic [7:0]  cbits;
    int          w;
    int          h;
    bit          cursor_on;
    out_item_t   row;
    cursor_on = (it.op == OP_DRAW_CURSOR);
    case (it.op)
      OP_LOAD_FONT: begin
        font_rows[int'(it.char_code)*GLYPH_ROWS + int'(it.glyph_row)] = it.glyph_bits;
      end
      OP_LOAD_CURSOR: begin
        cursor_rows[it.glyph_row] = it.glyph_bits;
      end
      default: begin
        code = it.char_code;
        fg   = it.fg_color;
        if (cursor_on && (code == NUL_CODE || code == BLANK_CODE)) begin
          code = BLANK_CODE;
          fg   = model_cfg.caret_color;
        end
        w = (model_cfg.font_width > PIXEL_LANES) ? PIXEL_LANES : int'(model_cfg.font_width);
        h = (model_cfg.font_height > RESULT_ROWS_MAX) ? RESULT_ROWS_MAX
                                                      : int'(model_cfg.font_height);
        for (int r = 0; r < h; r++) begin
          gbits = font_rows[int'(code)*GLYPH_ROWS + r];
          cbits = cursor_on ? cursor_rows[r] : 8'h00;
          line_no = 32'(it.cell_row) * 32'(h) + 32'(r);
          row.pixel_address = model_cfg.frame_base + 32'd4 *
              (line_no * 32'(model_cfg.line_pitch) + 32'(it.column) * 32'(w));
          row.pixel_mask = '0;
          for (int k = 0; k < PIXEL_LANES; k++) begin
            if (k < w) begin
              row.pixel_mask[k] = 1'b1;
              row.pixels[k] = cbits[7-k] ? model_cfg.caret_color :
                              gbits[7-k] ? fg : it.bg_color;
            end else begin
              row.pixels[k] = '0;
            end
          end
          row.last_row = (r == h - 1);
          expected_rows.push_back(row);
        end
      end
    endcase
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %h, actual %h", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (expected_rows.size() == 0) begin
        $error("pixel_address: expected no result, actual %h", out_if.pixel_address);
        mismatches++;
      end else begin
        want_row = expected_rows.pop_front();
        got_px[0] = out_if.pixel_0;
        got_px[1] = out_if.pixel_1;
        got_px[2] = out_if.pixel_2;
        got_px[3] = out_if.pixel_3;
        got_px[4] = out_if.pixel_4;
        got_px[5] = out_if.pixel_5;
        got_px[6] = out_if.pixel_6;
        got_px[7] = out_if.pixel_7;
        check_field("pixel_address", want_row.pixel_address, out_if.pixel_address);
        for (int k = 0; k < PIXEL_LANES; k++) begin
          check_field($sformatf("pixel_%0d", k), want_row.pixels[k], got_px[k]);
        end
        check_field("pixel_mask", 32'(want_row.pixel_mask), 32'(out_if.pixel_mask));
        check_field("last_row", 32'(want_row.last_row), 32'(out_if.last_row));
      end
    end
  end

  always @(negedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode = stall_e'($urandom_range(0, 3));
      stall_left = $urandom_range(16, 128);
    end
    stall_left--;
    case (stall_mode)
      RX_OPEN:   out_if.ready <= 1'b1;
      RX_COIN:   out_if.ready <= 1'($urandom_range(0, 1));
      RX_SPARSE: out_if.ready <= ($urandom_range(0, 4) == 0);
      default:   out_if.ready <= ((stall_left % 6) < 4);
    endcase
  end

  task automatic hold_off();
    @(negedge clk_i);
    in_if.valid <= 1'b0;
  endtask

  // Stops driving requests and waits until no result is still expected.
  task automatic drain();
    hold_off();
    while (expected_rows.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic send_item(input in_item_t it, input bit typed = 1'b0,
                           input out_item_t typed_row = '0);
    @(negedge clk_i);
    in_if.valid      <= 1'b1;
    in_if.op         <= it.op;
    in_if.char_code  <= it.char_code;
    in_if.glyph_row  <= it.glyph_row;
    in_if.glyph_bits <= it.glyph_bits;
    in_if.column     <= it.column;
    in_if.cell_row   <= it.cell_row;
    in_if.fg_color   <= it.fg_color;
    in_if.bg_color   <= it.bg_color;
    do @(posedge clk_i); while (!in_if.ready);
    sent++;
    if (typed) begin
      expected_rows.push_back(typed_row);
    end else begin
      predict_request(it);
    end
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      hold_off();
      repeat ($urandom_range(0, 10)) @(negedge clk_i);
    end
  endtask

  task automatic reg_write(input logic [2:0] idx, input logic [31:0] value);
    drain();
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      REG_FONT_WIDTH:   model_cfg.font_width   = value[3:0];
      REG_FONT_HEIGHT:  model_cfg.font_height  = value[4:0];
      REG_LINE_PITCH:   model_cfg.line_pitch   = value[12:0];
      REG_FRAME_BASE:   model_cfg.frame_base   = value;
      REG_CARET_COLOR:  model_cfg.caret_color  = value;
      default: ;
    endcase
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  function automatic in_item_t random_req(op_e op, logic [7:0] code, logic [3:0] grow);
    in_item_t it;
    it.op         = op;
    it.char_code  = code;
    it.glyph_row  = grow;
    it.glyph_bits = 8'($urandom_range(0, 255));
    it.column     = 9'($urandom_range(0, 511));
    it.cell_row   = 8'($urandom_range(0, 255));
    it.fg_color   = $urandom;
    it.bg_color   = $urandom;
    return it;
  endfunction

  task automatic load_glyph(input logic [7:0] code, input int rows);
    for (int r = 0; r < rows; r++) begin
      send_item(random_req(OP_LOAD_FONT, code, 4'(r)));
    end
    if (rows == GLYPH_ROWS && !listed[code]) begin
      listed[code] = 1'b1;
      drawable.push_back(code);
    end
  endtask

  function automatic step_t reg_step(logic [2:0] idx, logic [31:0] value);
    step_t s;
    s.kind    = STEP_REG_WRITE;
    s.reg_idx = idx;
    s.reg_val = value;
    s.req     = '0;
    s.typed   = 1'b0;
    s.res     = '0;
    return s;
  endfunction

  function automatic step_t req_step(op_e op, logic [7:0] code, logic [3:0] grow,
                                     logic [7:0] bits, logic [8:0] col, logic [7:0] crow,
                                     logic [31:0] fg, logic [31:0] bg);
    step_t s;
    s.kind    = STEP_REQUEST;
    s.reg_idx = '0;
    s.reg_val = '0;
    s.req     = '{op: op, char_code: code, glyph_row: grow, glyph_bits: bits,
                  column: col, cell_row: crow, fg_color: fg, bg_color: bg};
    s.typed   = 1'b0;
    s.res     = '0;
    return s;
  endfunction

  function automatic step_t typed_step(step_t s, logic [31:0] addr, logic [7:0] mask,
                                       logic [31:0] p0, logic [31:0] p1, logic [31:0] p2,
                                       logic [31:0] p3, logic [31:0] p4, logic [31:0] p5,
                                       logic [31:0] p6, logic [31:0] p7);
    s.typed = 1'b1;
    s.res.pixel_address = addr;
    s.res.pixels[0] = p0;
    s.res.pixels[1] = p1;
    s.res.pixels[2] = p2;
    s.res.pixels[3] = p3;
    s.res.pixels[4] = p4;
    s.res.pixels[5] = p5;
    s.res.pixels[6] = p6;
    s.res.pixels[7] = p7;
    s.res.pixel_mask = mask;
    s.res.last_row = 1'b1;
    return s;
  endfunction

  initial begin
    int          phase_start;
    int          pick;
    logic [7:0]  code;
    logic [31:0] fw;
    logic [31:0] fh;
    logic [31:0] pitch;
    logic [31:0] base;
    logic [31:0] ccolor;

    rst_ni           = 1'b0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    in_if.valid      = 1'b0;
    in_if.op         = OP_LOAD_FONT;
    in_if.char_code  = '0;
    in_if.glyph_row  = '0;
    in_if.glyph_bits = '0;
    in_if.column     = '0;
    in_if.cell_row   = '0;
    in_if.fg_color   = '0;
    in_if.bg_color   = '0;
    out_if.ready     = 1'b0;

    model_cfg.font_width   = RST_FONT_WIDTH;
    model_cfg.font_height  = RST_FONT_HEIGHT;
    model_cfg.line_pitch   = RST_LINE_PITCH;
    model_cfg.frame_base   = RST_FRAME_BASE;
    model_cfg.caret_color  = RST_CARET_COLOR;
    foreach (font_rows[i]) font_rows[i] = '0;
    foreach (cursor_rows[i]) cursor_rows[i] = '0;

    steps.push_back(reg_step(REG_FONT_HEIGHT, 32'd1));
    steps.push_back(req_step(OP_LOAD_CURSOR, 8'd0, 4'd0, 8'h81, 9'd0, 8'd0, '0, '0));
    steps.push_back(req_step(OP_LOAD_CURSOR, 8'd0, 4'd15, 8'hFF, 9'd0, 8'd0, '0, '0));
    steps.push_back(req_step(OP_LOAD_FONT, NUL_CODE, 4'd0, 8'hFF, 9'd0, 8'd0, '0, '0));
    steps.push_back(req_step(OP_LOAD_FONT, BLANK_CODE, 4'd0, 8'h00, 9'd0, 8'd0, '0, '0));
    steps.push_back(req_step(OP_LOAD_FONT, 8'd255, 4'd0, 8'hA5, 9'd0, 8'd0, '0, '0));
    steps.push_back(req_step(OP_LOAD_FONT, 8'd255, 4'd15, 8'h5A, 9'd0, 8'd0, '0, '0));
    steps.push_back(typed_step(
        req_step(OP_DRAW, NUL_CODE, 4'd0, 8'd0, 9'd0, 8'd0, 32'hFFFF_FFFF, 32'h0),
        32'h0, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
        32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    steps.push_back(typed_step(
        req_step(OP_DRAW, 8'd255, 4'd0, 8'd0, 9'd511, 8'd255, 32'h1234_5678, 32'h9ABC_DEF0),
        32'h0010_2FE0, 8'hFF, 32'h1234_5678, 32'h9ABC_DEF0, 32'h1234_5678, 32'h9ABC_DEF0,
        32'h9ABC_DEF0, 32'h1234_5678, 32'h9ABC_DEF0, 32'h1234_5678));
    steps.push_back(typed_step(
        req_step(OP_DRAW_CURSOR, NUL_CODE, 4'd0, 8'd0, 9'd1, 8'd1, 32'h1111_1111,
                 32'hDEAD_BEEF),
        32'h0000_1020, 8'hFF, 32'h00FF_FFFF, 32'hDEAD_BEEF, 32'hDEAD_BEEF, 32'hDEAD_BEEF,
        32'hDEAD_BEEF, 32'hDEAD_BEEF, 32'hDEAD_BEEF, 32'h00FF_FFFF));
    steps.push_back(req_step(OP_DRAW_CURSOR, BLANK_CODE, 4'd0, 8'd0, 9'd2, 8'd3,
                             32'h2468_ACE0, 32'h1357_9BDF));
    steps.push_back(req_step(OP_DRAW_CURSOR, 8'd255, 4'd0, 8'd0, 9'd100, 8'd7,
                             32'h0F0F_0F0F, 32'hF0F0_F0F0));
    steps.push_back(reg_step(REG_CARET_COLOR, 32'h0));
    steps.push_back(reg_step(REG_FRAME_BASE, 32'hFFFF_FFFF));
    steps.push_back(reg_step(REG_LINE_PITCH, 32'd8191));
    steps.push_back(reg_step(REG_FONT_WIDTH, 32'd15));
    steps.push_back(req_step(OP_DRAW, 8'd255, 4'd0, 8'd0, 9'd3, 8'd2,
                             32'hAAAA_AAAA, 32'h5555_5555));
    steps.push_back(reg_step(REG_FONT_WIDTH, 32'd0));
    steps.push_back(typed_step(
        req_step(OP_DRAW, NUL_CODE, 4'd0, 8'd0, 9'd5, 8'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF),
        32'hFFFF_FFFF, 8'h00, '0, '0, '0, '0, '0, '0, '0, '0));
    steps.push_back(reg_step(REG_LINE_PITCH, 32'd0));
    steps.push_back(reg_step(REG_FONT_WIDTH, 32'd1));
    steps.push_back(typed_step(
        req_step(OP_DRAW_CURSOR, BLANK_CODE, 4'd0, 8'd0, 9'd7, 8'd9, 32'h0123_4567,
                 32'h89AB_CDEF),
        32'h0000_001B, 8'h01, '0, '0, '0, '0, '0, '0, '0, '0));
    steps.push_back(typed_step(
        req_step(OP_DRAW, 8'd255, 4'd0, 8'd0, 9'd0, 8'd0, 32'h0F0F_0F0F, 32'h0),
        32'hFFFF_FFFF, 8'h01, 32'h0F0F_0F0F, '0, '0, '0, '0, '0, '0, '0));
    steps.push_back(reg_step(REG_FONT_HEIGHT, 32'd0));
    steps.push_back(req_step(OP_DRAW, 8'd255, 4'd0, 8'd0, 9'd9, 8'd4,
                             32'hCAFE_0001, 32'h0BAD_0002));
    steps.push_back(req_step(OP_DRAW_CURSOR, NUL_CODE, 4'd0, 8'd0, 9'd10, 8'd5,
                             32'hCAFE_0003, 32'h0BAD_0004));

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (steps[i]) begin
      if (steps[i].kind == STEP_REG_WRITE) begin
        reg_write(steps[i].reg_idx, steps[i].reg_val);
      end else begin
        send_item(steps[i].req, steps[i].typed, steps[i].res);
      end
    end

    reg_write(REG_FONT_HEIGHT, 32'd16);
    for (int r = 0; r < CURSOR_ROWS; r++) begin
      send_item(random_req(OP_LOAD_CURSOR, 8'($urandom_range(0, 255)), 4'(r)));
    end
    load_glyph(BLANK_CODE, GLYPH_ROWS);
    load_glyph(NUL_CODE, GLYPH_ROWS);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          fw = 8; fh = 16; pitch = 4096; base = $urandom; ccolor = $urandom;
        end
        1: begin
          fw = 1; fh = 1; pitch = 1; base = 0; ccolor = 0;
        end
        2: begin
          fw = 15; fh = 31; pitch = 8191; base = 32'hFFFF_FFFF; ccolor = 32'hFFFF_FFFF;
        end
        default: begin
          fw = $urandom_range(0, 15);
          fh = $urandom_range(1, 31);
          pitch = $urandom_range(0, 8191);
          base = $urandom;
          ccolor = $urandom;
        end
      endcase
      reg_write(REG_FONT_WIDTH, fw);
      reg_write(REG_FONT_HEIGHT, fh);
      reg_write(REG_LINE_PITCH, pitch);
      reg_write(REG_FRAME_BASE, base);
      reg_write(REG_CARET_COLOR, ccolor);
      phase_start = sent;
      while (sent - phase_start < PHASE_ITEMS) begin
        pick = $urandom_range(0, 9);
        if (pick < 2) begin
          send_item(random_req($urandom_range(0, 1) ? OP_LOAD_FONT : OP_LOAD_CURSOR,
                               8'($urandom_range(0, 255)), 4'($urandom_range(0, 15))));
        end else if (pick < 5) begin
          send_item(random_req($urandom_range(0, 1) ? OP_DRAW : OP_DRAW_CURSOR,
                               drawable[$urandom_range(0, drawable.size() - 1)],
                               4'($urandom_range(0, 15))));
        end else if (pick == 5) begin
          load_glyph(8'($urandom_range(0, 255)), $urandom_range(1, GLYPH_ROWS - 1));
        end else if (pick == 6) begin
          drain();
        end else begin
          code = 8'($urandom_range(0, 255));
          load_glyph(code, GLYPH_ROWS);
          repeat ($urandom_range(1, 3)) begin
            send_item(random_req($urandom_range(0, 1) ? OP_DRAW : OP_DRAW_CURSOR, code,
                                 4'($urandom_range(0, 15))));
          end
        end
      end
    end

    drain();
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

### glyph_cell_renderer_core.f
src/gcr_pkg.sv
src/gcr_in_if.sv
src/gcr_out_if.sv
src/gcr_ctrl.sv
src/gcr_dp.sv
src/glyph_cell_renderer_core.sv
bench/glyph_cell_renderer_core_test.sv
